FILE: design/sgcd_pkg.sv
// sgcd_pkg: shared types for the signed extended gcd block.
// Controller state encoding and the command/status bundles between controller and datapath.
// No dependencies.
package sgcd_pkg;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;      // capture operands, set up Euclid registers
    logic div_init;  // clear partial remainder, products and bit counter
    logic div_step;  // one restoring division bit
    logic update;    // advance Euclid recurrence by one step
    logic finish;    // write result into output registers
  } cmd_t;

  typedef struct packed {
    logic special;   // an operand magnitude is zero
    logic div_last;  // current division bit is the final one
    logic rem_zero;  // remainder of last division is zero
  } status_t;

endpackage

FILE: design/signed_extended_gcd.sv
// signed_extended_gcd: top level, gcd and Bezout coefficients of two signed operands.
// Instantiates sgcd_ctrl and sgcd_datapath; uses sgcd_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | in_valid / in_stall  | operand_a, operand_b
//   output   | out_valid / out_stall| divisor, coef_a, coef_b
//
// One item at a time. Each item runs n Euclid divisions, n from 1 to 44 at 32
// bits; an operand with zero magnitude skips the divisions.
// Each division runs on the shared
// restoring divider, one quotient bit a cycle, with q*s and q*t built alongside.
// Reset (rst, synchronous) clears the sequencer and output valid only.
// Output register lets the next transfer in while a result waits under out_stall;
// a finished item holds in the finish state until that register is free.
module signed_extended_gcd #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [DATA_WIDTH-2:0] divisor,
  output logic signed [DATA_WIDTH-1:0] coef_a,
  output logic signed [DATA_WIDTH-1:0] coef_b
);

  sgcd_pkg::cmd_t    cmd;
  sgcd_pkg::status_t status;

  // sequencer: owns both handshakes
  sgcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: Euclid registers, divider, sign handling, output payload
  sgcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .divisor   (divisor),
    .coef_a    (coef_a),
    .coef_b    (coef_b)
  );

endmodule

FILE: design/sgcd_datapath.sv
// sgcd_datapath: magnitude/sign split, shared bit-serial divider with coefficient
// accumulation, Euclid registers and output payload registers.
// Depends on sgcd_pkg.
module sgcd_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  sgcd_pkg::cmd_t               cmd,
  output sgcd_pkg::status_t            status,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output logic        [DATA_WIDTH-2:0] divisor,
  output logic signed [DATA_WIDTH-1:0] coef_a,
  output logic signed [DATA_WIDTH-1:0] coef_b
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0] mag_a, mag_b;
  logic         neg_a_in, neg_b_in;

  // Euclid registers
  logic [W-1:0] r0, r1, s0, s1, t0, t1;
  logic         na, nb, swapped, za, zb;

  // divider registers
  logic [W-1:0]  dvd, rem, prod_s, prod_t;
  logic [CW-1:0] cnt;

  logic [W:0]   cur;
  logic         ge;
  logic [W:0]   diff;
  logic [W-1:0] rem_next;

  logic [W-1:0] g_sel, x_sel, y_sel, cs, ct;

  assign neg_a_in = operand_a[W-1];
  assign neg_b_in = operand_b[W-1];
  // most negative value yields 2^(W-1), which still fits unsigned W bits
  assign mag_a = neg_a_in ? (~operand_a + 1'b1) : operand_a;
  assign mag_b = neg_b_in ? (~operand_b + 1'b1) : operand_b;

  assign cur      = {rem, dvd[W-1]};
  assign diff     = cur - {1'b0, r1};
  assign ge       = (cur >= {1'b0, r1});
  assign rem_next = ge ? diff[W-1:0] : cur[W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      na      <= neg_a_in;
      nb      <= neg_b_in;
      za      <= (mag_a == '0);
      zb      <= (mag_b == '0);
      swapped <= (mag_a < mag_b);
      r0      <= (mag_a < mag_b) ? mag_b : mag_a;
      r1      <= (mag_a < mag_b) ? mag_a : mag_b;
      s0      <= W'(1);
      s1      <= '0;
      t0      <= '0;
      t1      <= W'(1);
    end else if (cmd.update) begin
      r0 <= r1;
      r1 <= rem;
      s0 <= s1;
      s1 <= s0 - prod_s;
      t0 <= t1;
      t1 <= t0 - prod_t;
    end
  end

  // quotient bits come MSB first, so q*s1 and q*t1 build up by Horner's rule
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd    <= r0;
      rem    <= '0;
      prod_s <= '0;
      prod_t <= '0;
      cnt    <= '0;
    end else if (cmd.div_step) begin
      dvd    <= {dvd[W-2:0], 1'b0};
      rem    <= rem_next;
      prod_s <= {prod_s[W-2:0], 1'b0} + (ge ? s1 : '0);
      prod_t <= {prod_t[W-2:0], 1'b0} + (ge ? t1 : '0);
      cnt    <= cnt + 1'b1;
    end
  end

  assign status.special  = za | zb;
  assign status.div_last = (cnt == CW'(W - 1));
  assign status.rem_zero = (rem == '0);

  assign cs = swapped ? t1 : s1;
  assign ct = swapped ? s1 : t1;

  always_comb begin
    if (za && zb) begin
      g_sel = '0;
      x_sel = W'(1);
      y_sel = W'(1);
    end else if (za) begin
      g_sel = r0;
      x_sel = '0;
      y_sel = nb ? '1 : W'(1);
    end else if (zb) begin
      g_sel = r0;
      x_sel = na ? '1 : W'(1);
      y_sel = '0;
    end else begin
      g_sel = r1;
      x_sel = na ? (~cs + 1'b1) : cs;
      y_sel = nb ? (~ct + 1'b1) : ct;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      divisor <= g_sel[W-2:0];
      coef_a  <= x_sel;
      coef_b  <= y_sel;
    end
  end

endmodule

FILE: design/sgcd_ctrl.sv
// sgcd_ctrl: sequencer for load, per-step division, recurrence update and result transfer.
// Owns the handshake flags. Depends on sgcd_pkg.
module sgcd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sgcd_pkg::status_t  status,
  output sgcd_pkg::cmd_t     cmd
);

  sgcd_pkg::state_t state, state_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != sgcd_pkg::ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      sgcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sgcd_pkg::ST_START;
        end
      end
      sgcd_pkg::ST_START: begin
        if (status.special) begin
          state_next = sgcd_pkg::ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = sgcd_pkg::ST_DIV;
        end
      end
      sgcd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = sgcd_pkg::ST_UPDATE;
        end
      end
      sgcd_pkg::ST_UPDATE: begin
        if (status.rem_zero) begin
          state_next = sgcd_pkg::ST_FINISH;
        end else begin
          cmd.update = 1'b1;
          state_next = sgcd_pkg::ST_START;
        end
      end
      sgcd_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = sgcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sgcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sgcd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/sgcd_checker.sv
// sgcd_checker: port-level assertions for signed_extended_gcd, attached by bind.
// Sees only the top-level ports.
module sgcd_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [DATA_WIDTH-1:0] operand_a,
  input logic [DATA_WIDTH-1:0] operand_b,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-2:0] divisor,
  input logic [DATA_WIDTH-1:0] coef_a,
  input logic [DATA_WIDTH-1:0] coef_b
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(divisor) && $stable(coef_a) && $stable(coef_b))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while item in progress");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while still busy");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left result valid or input stalled");

endmodule

bind signed_extended_gcd sgcd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sgcd_checker (.*);

FILE: dv/tb_signed_extended_gcd.sv
`timescale 1ns / 100ps
// tb_signed_extended_gcd: self-checking testbench for the signed extended gcd block.
// Needs only signed_extended_gcd and what it instantiates; no files, no arguments.
module tb_signed_extended_gcd;

  localparam int W = 32;

  // Longest correct gap between transfers: the worst-case Euclid work plus
  // sender gaps and receiver stalls, taken well over ten times.
  localparam int IDLE_LIMIT  = 20000;
  // Settle time once the last result is in.
  localparam int DRAIN_TICKS = 64;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int PRINT_CAP   = 40;

  localparam logic [W-1:0] OP_MAX = {1'b0, {(W-1){1'b1}}};

  // One predicted result, with the operands that caused it for the log.
  typedef struct {
    logic [W-1:0] opa;
    logic [W-1:0] opb;
    logic [W-2:0] divisor;
    logic [W-1:0] coef_a;
    logic [W-1:0] coef_b;
  } bezout_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;
  logic         out_valid;
  logic         out_stall;
  logic [W-2:0] divisor;
  logic [W-1:0] coef_a;
  logic [W-1:0] coef_b;

  bezout_t     bezout_q[$];   // predicted results, oldest first
  int unsigned error_count;
  int unsigned idle_ticks;
  int unsigned send_idle_pct; // chance per cycle that the sender holds off
  int unsigned stall_pct;     // chance per cycle that the receiver stalls

  signed_extended_gcd #(
    .DATA_WIDTH(W)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .divisor   (divisor),
    .coef_a    (coef_a),
    .coef_b    (coef_b)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction: extended Euclid on the magnitudes, larger one first (a wins a
  // tie), coefficients kept modulo 2^64, swapped back, then signed and masked.
  // ---------------------------------------------------------------------------
  function automatic bezout_t predict_bezout(input logic [W-1:0] a, input logic [W-1:0] b);
    bezout_t      res;
    logic         neg_a, neg_b, swapped;
    logic [W-1:0] abs_a, abs_b;
    logic [63:0]  mag_a, mag_b, r0, r1, s0, s1, t0, t1;
    logic [63:0]  quo, rem, nxt_s, nxt_t, g, x, y;
    neg_a = a[W-1];
    neg_b = b[W-1];
    // negate at the operand width so the most negative value maps to 2^(W-1)
    abs_a = neg_a ? -a : a;
    abs_b = neg_b ? -b : b;
    mag_a = abs_a;
    mag_b = abs_b;
    if (mag_a == 0 && mag_b == 0) begin
      g = 0;
      x = 1;
      y = 1;
    end else if (mag_a == 0) begin
      g = mag_b;
      x = 0;
      y = neg_b ? -64'd1 : 64'd1;
    end else if (mag_b == 0) begin
      g = mag_a;
      x = neg_a ? -64'd1 : 64'd1;
      y = 0;
    end else begin
      swapped = mag_a < mag_b;
      r0 = swapped ? mag_b : mag_a;
      r1 = swapped ? mag_a : mag_b;
      // s tracks the coefficient of the larger magnitude, t of the smaller
      s0 = 1;
      s1 = 0;
      t0 = 0;
      t1 = 1;
      rem = r0 % r1;
      while (rem != 0) begin
        quo   = r0 / r1;
        nxt_s = s0 - s1 * quo;
        nxt_t = t0 - t1 * quo;
        r0 = r1;
        r1 = rem;
        s0 = s1;
        s1 = nxt_s;
        t0 = t1;
        t1 = nxt_t;
        rem = r0 % r1;
      end
      g = r1;
      x = swapped ? t1 : s1;
      y = swapped ? s1 : t1;
      if (neg_a) x = -x;
      if (neg_b) y = -y;
    end
    res.opa     = a;
    res.opb     = b;
    res.divisor = g[W-2:0];
    res.coef_a  = x[W-1:0];
    res.coef_b  = y[W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line each, printing capped, counting never capped.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [W-1:0] opa,
                                 input logic [W-1:0] opb, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("%0t ERROR %s: a=%0d b=%0d got %h want %h", $realtime, what,
               $signed(opa), $signed(opb), got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: random hold-off, then present the operands and keep them steady
  // until the transfer. in_valid is only ever lowered while holding off, so a
  // back-to-back item never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_operands(input logic [W-1:0] a, input logic [W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
    bezout_q.push_back(predict_bezout(a, b));
  endtask

  // Random magnitude of 1 to W-1 bits, so that small and full-size values mix.
  function automatic logic [W-1:0] rand_magnitude(input int unsigned bits);
    logic [W-1:0] v;
    v = $urandom;
    v[W-1] = 1'b0;
    return v >> (W - 1 - bits);
  endfunction

  function automatic logic [W-1:0] rand_signed(input logic [W-1:0] mag);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Both zero, and one zero with the other of either sign, up to full scale.
  task automatic test_zero_operands();
    send_operands(0, 0);
    send_operands(0, 5);
    send_operands(0, -7);
    send_operands(9, 0);
    send_operands(-9, 0);
    send_operands(0, OP_MAX);
    send_operands(-OP_MAX, 0);
  endtask

  // Equal magnitudes in all sign combinations: gcd is |b|, coefficient on b.
  task automatic test_equal_magnitudes();
    send_operands(12, 12);
    send_operands(-12, 12);
    send_operands(12, -12);
    send_operands(-12, -12);
    send_operands(OP_MAX, OP_MAX);
    send_operands(-OP_MAX, -OP_MAX);
    send_operands(1, -1);
  endtask

  // Full-scale operands, unit operands, and a smaller a forcing the swap.
  task automatic test_range_extremes();
    send_operands(OP_MAX, OP_MAX - 1);
    send_operands(-OP_MAX, 1);
    send_operands(OP_MAX, -2);
    send_operands(1, OP_MAX);
    send_operands(-1, -OP_MAX);
    send_operands(6, 35);
    send_operands(-35, 6);
  endtask

  // Consecutive Fibonacci numbers give the longest division chains.
  task automatic test_long_chains();
    send_operands(32'd1836311903, 32'd1134903170);
    send_operands(-32'd1134903170, 32'd1836311903);
    send_operands(32'd1836311903, -32'd1134903170);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic under one idling pattern. Most items are independent operands
  // of random size; some share a common factor so the gcd is not usually 1, and a
  // few hit a zero operand or equal magnitudes.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned rx_pct);
    logic [W-1:0] a, b, common;
    int unsigned  kind, gbits;
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
    repeat (count) begin
      kind = $urandom_range(99);
      a = rand_signed(rand_magnitude($urandom_range(W - 1, 1)));
      b = rand_signed(rand_magnitude($urandom_range(W - 1, 1)));
      if (kind < 5) begin
        if ($urandom_range(1)) a = 0;
        else b = 0;
      end else if (kind < 8) begin
        b = rand_signed(a[W-1] ? -a : a);
      end else if (kind < 35) begin
        gbits  = $urandom_range(12, 1);
        common = rand_magnitude(gbits);
        a = rand_signed(common * rand_magnitude($urandom_range(W - 2 - gbits, 1)));
        b = rand_signed(common * rand_magnitude($urandom_range(W - 2 - gbits, 1)));
      end
      send_operands(a, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, redrawn every cycle at the current rate.
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Result check: every result transfer against the oldest prediction.
  always @(posedge clk) begin
    bezout_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bezout_q.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0, coef_a, 0);
      end else begin
        want = bezout_q.pop_front();
        if (divisor !== want.divisor)
          report_mismatch("divisor", want.opa, want.opb, {1'b0, divisor},
                          {1'b0, want.divisor});
        if (coef_a !== want.coef_a)
          report_mismatch("coef_a", want.opa, want.opb, coef_a, want.coef_a);
        if (coef_b !== want.coef_b)
          report_mismatch("coef_b", want.opa, want.opb, coef_b, want.coef_b);
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_ticks <= 0;
    end else if (idle_ticks >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_ticks <= idle_ticks + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    operand_a     = '0;
    operand_b     = '0;
    out_stall     = 1'b0;
    error_count   = 0;
    idle_ticks    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part with no idling on either side
    test_zero_operands();
    test_equal_magnitudes();
    test_range_extremes();
    test_long_chains();

    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 82, 0);
    test_random_traffic(100, 0, 82);
    test_random_traffic(100, 35, 35);

    in_valid <= 1'b0;
    while (bezout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
